FILE: rtl/rational_arithmetic_unit_assert.svh
// Assertion macros shared by the rational arithmetic unit files.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
// Check a property on every clock edge outside reset.
`define RAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies another in the following cycle.
`define RAU_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);
`endif

FILE: rtl/rau_pkg.sv
// Package: shared types and codes of the rational arithmetic unit.
`default_nettype none
package rau_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIVZ  = 2'd1,
    ST_OVFL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  localparam int unsigned NumW = 32;
  localparam int unsigned DenW = 31;
  localparam int unsigned MagW = 64;

  // Job passed from the front end to the back end.
  typedef struct packed {
    logic            early;   // result already known, no reduction
    logic [1:0]      status;
    logic            neg;
    logic [MagW-1:0] mag;
    logic [MagW-1:0] den;
  } job_t;
endpackage
`default_nettype wire

FILE: rtl/rau_if.sv
// Interfaces: input and output channels of the rational arithmetic unit.
`default_nettype none
interface rau_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] a_num;
  logic [30:0] a_den;
  logic [31:0] b_num;
  logic [30:0] b_den;
  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/rau_front.sv
// Front end: accepts a request, forms the cross products in F_MUL1 and F_MUL2, classifies it.
`default_nettype none
module rau_front import rau_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rau_req_if.sink    req,
  output logic       job_valid_o,
  input  wire logic  job_ready_i,
  output job_t       job_o
);
  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL1 = 4'b0010,
    F_MUL2 = 4'b0100,
    F_DONE = 4'b1000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [1:0]         op_q;
  logic signed [32:0] an_q, bn_q;   // bn negated for divide by negative
  logic               bneg_q;
  logic [30:0]        ad_q, bd_q;
  logic               divz_q;
  logic signed [64:0] p1_q, p2_q;
  logic [63:0]        den_q;
  logic signed [65:0] num_s;
  logic [65:0]        mag_s;

  assign req.ready = (state_q == F_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (req.valid) state_d = F_MUL1;
      F_MUL1: state_d = F_MUL2;
      F_MUL2: state_d = F_DONE;
      F_DONE: if (job_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && req.valid) begin
      op_q   <= req.req_type;
      an_q   <= 33'(signed'(req.a_num));
      ad_q   <= req.a_den;
      bd_q   <= req.b_den;
      bneg_q <= req.b_num[31];
      divz_q <= (req.a_den == '0) || (req.b_den == '0) ||
                (req.req_type == OP_DIV && req.b_num == '0);
      if (req.req_type == OP_DIV && req.b_num[31])
        bn_q <= -33'(signed'(req.b_num));
      else
        bn_q <= 33'(signed'(req.b_num));
    end
    if (state_q == F_MUL1) begin
      // one product per operand pair, registered
      unique case (op_q)
        OP_MUL: begin
          p1_q  <= 65'(an_q * bn_q);
          den_q <= 64'(ad_q) * 64'(bd_q);
        end
        OP_DIV: begin
          p1_q  <= bneg_q ? 65'(-(an_q * $signed({1'b0, bd_q})))
                          : 65'(an_q * $signed({1'b0, bd_q}));
          den_q <= 64'(ad_q) * 64'(bn_q[31:0]);
        end
        default: begin
          p1_q  <= 65'(an_q * $signed({1'b0, bd_q}));
          den_q <= 64'(ad_q) * 64'(bd_q);
        end
      endcase
    end
    if (state_q == F_MUL2) begin
      unique case (op_q)
        OP_ADD:  p2_q <= 65'(p1_q + 65'(bn_q * $signed({1'b0, ad_q})));
        OP_SUB:  p2_q <= 65'(p1_q - 65'(bn_q * $signed({1'b0, ad_q})));
        default: p2_q <= p1_q;
      endcase
    end
  end

  // Divide by a negative bn: bn_q holds -bn, so the numerator sign is flipped in MUL1.
  assign num_s = 66'(p2_q);
  assign mag_s = num_s[65] ? 66'(-num_s) : num_s;

  assign job_valid_o  = (state_q == F_DONE);
  assign job_o.early  = divz_q || (p2_q == '0);
  assign job_o.status = divz_q ? ST_DIVZ : ST_OK;
  assign job_o.neg    = num_s[65];
  assign job_o.mag    = mag_s[63:0];
  assign job_o.den    = den_q;
endmodule
`default_nettype wire

FILE: rtl/rau_fifo.sv
// Two-entry queue of jobs between the front end and the back end.
`default_nettype none
module rau_fifo import rau_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  job_t      in_job_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output job_t      out_job_o
);
  job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_job_o   = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_job_i;
  end
endmodule
`default_nettype wire

FILE: rtl/rau_divider.sv
// Restoring divider, one quotient bit per cycle, 64-bit operands.
`default_nettype none
module rau_divider import rau_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [MagW-1:0] dividend_i,
  input  wire logic [MagW-1:0] divisor_i,
  output logic                 done_o,
  output logic [MagW-1:0]      quot_o,
  output logic [MagW-1:0]      rem_o
);
  localparam int unsigned CntW = $clog2(MagW + 1);
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [MagW-1:0] q_q, r_q, d_q;
  logic [MagW:0]   shifted;
  logic [MagW:0]   diff;

  assign shifted = {r_q, q_q[MagW-1]};
  assign diff    = shifted - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(MagW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[MagW]) begin
        r_q <= diff[MagW-1:0];
        q_q <= {q_q[MagW-2:0], 1'b1};
      end else begin
        r_q <= shifted[MagW-1:0];
        q_q <= {q_q[MagW-2:0], 1'b0};
      end
    end
  end

  assign quot_o = q_q;
  assign rem_o  = r_q;
endmodule
`default_nettype wire

FILE: rtl/rau_back.sv
// Back end: Euclidean gcd on the shared divider, reduction, range check, result register.
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rau_back import rau_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  output logic       job_ready_o,
  input  job_t       job_i,
  rau_res_if.source  res
);
  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_GCD  = 6'b000010,
    B_RDN  = 6'b000100,
    B_RDD  = 6'b001000,
    B_CHK  = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_e;

  localparam logic [MagW-1:0] LimPos = MagW'((64'd1 << (WIDTH - 1)) - 64'd1);
  localparam logic [MagW-1:0] LimNeg = MagW'(64'd1 << (WIDTH - 1));

  bstate_e state_q, state_d;
  logic            wait_q;
  logic            neg_q;
  logic [MagW-1:0] mag_q, den_q, x_q, y_q;
  logic [NumW-1:0] onum_q;
  logic [DenW-1:0] oden_q;
  logic [1:0]      ost_q;
  logic            dv_start;
  logic [MagW-1:0] dv_a, dv_b, dv_q, dv_r;
  logic            dv_done;
  logic [MagW-1:0] nmag;

  rau_divider u_div (
    .clk_i, .rst_ni,
    .start_i(dv_start), .dividend_i(dv_a), .divisor_i(dv_b),
    .done_o(dv_done), .quot_o(dv_q), .rem_o(dv_r)
  );

  assign job_ready_o = (state_q == B_IDLE);

  always_comb begin
    dv_start = 1'b0;
    dv_a = x_q;
    dv_b = y_q;
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (job_valid_i) state_d = job_i.early ? B_OUT : B_GCD;
      B_GCD: begin
        if (!wait_q && y_q != '0) dv_start = 1'b1;
        if (!wait_q && y_q == '0) state_d = B_RDN;
      end
      B_RDN: begin
        dv_a = mag_q;
        dv_b = x_q;
        dv_start = !wait_q;
        if (dv_done) state_d = B_RDD;
      end
      B_RDD: begin
        dv_a = den_q;
        dv_b = x_q;
        dv_start = !wait_q;
        if (dv_done) state_d = B_CHK;
      end
      B_CHK: state_d = B_OUT;
      B_OUT: if (res.ready) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (dv_start) wait_q <= 1'b1;
      else if (dv_done) wait_q <= 1'b0;
    end
  end

  assign nmag = 64'(-mag_q);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: if (job_valid_i) begin
        neg_q  <= job_i.neg;
        mag_q  <= job_i.mag;
        den_q  <= job_i.den;
        x_q    <= job_i.mag;
        y_q    <= job_i.den;
        onum_q <= '0;
        oden_q <= DenW'(1);
        ost_q  <= job_i.status;
      end
      B_GCD: if (dv_done) begin
        x_q <= y_q;
        y_q <= dv_r;
      end
      B_RDN: if (dv_done) mag_q <= dv_q;
      B_RDD: if (dv_done) den_q <= dv_q;
      B_CHK: begin
        if (den_q > LimPos || (neg_q ? mag_q > LimNeg : mag_q > LimPos)) begin
          ost_q <= ST_OVFL;
        end else begin
          onum_q <= neg_q ? nmag[NumW-1:0] : mag_q[NumW-1:0];
          oden_q <= den_q[DenW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign res.valid   = (state_q == B_OUT);
  assign res.res_num = onum_q;
  assign res.res_den = oden_q;
  assign res.status  = ost_q;

  `RAU_ASSERT(a_wait_gcd, !(dv_start && wait_q), "divider restarted while busy")
  `RAU_ASSERT_NEXT(a_out_hold, res.valid && !res.ready, res.valid && $stable(ost_q),
    "result changed under stall")
  `RAU_ASSERT(a_ok_den, !(res.valid && ost_q == ST_OK) || oden_q != '0,
    "ok result with zero denominator")
endmodule
`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
// Top level: rational arithmetic unit with gcd reduction.
// Usage: requests arrive on req (valid/ready); each word carries req_type
// (add, subtract, multiply, divide) and two rationals a_num/a_den, b_num/b_den.
// Every request word yields one result word on res: res_num/res_den reduced
// by the gcd, zero as 0/1, and status (ok, divide by zero, overflow).
// The front end takes a word in F_IDLE, forms the exact cross products in F_MUL1
// and F_MUL2 and offers the job in F_DONE; a two-entry queue passes it on.
// The back end runs Euclid's algorithm on one 64-bit restoring divider;
// two more divisions reduce the fraction. Zero results and divide by zero
// skip the divider. The back end takes a new word only after the result
// of the last one has been taken. Reset clears all control state; no word
// is in flight afterwards. When the receiver holds res.ready low the result
// stays put, the queue fills and then req.ready drops.
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rau_req_if.sink   req,
  rau_res_if.source res
);
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  rau_front u_front (
    .clk_i, .rst_ni, .req,
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  rau_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(fj_valid), .in_ready_o(fj_ready), .in_job_i(fj),
    .out_valid_o(bj_valid), .out_ready_i(bj_ready), .out_job_o(bj)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj), .res
  );

  `RAU_ASSERT(a_early_status, !(bj_valid && !bj.early) || bj.status == ST_OK,
    "reduction job with error status")
  `RAU_ASSERT(a_nonzero_den, !(bj_valid && !bj.early) || bj.den != '0,
    "reduction job with zero denominator")
  `RAU_ASSERT(a_nonzero_mag, !(bj_valid && !bj.early) || bj.mag != '0,
    "reduction job with zero numerator")
endmodule
`default_nettype wire
